/* hdl/cfwd_pkg.sv */
package cfwd_pkg;

	localparam int WORKERS_DEF = 64;

	localparam int SAL_W = 20;
	localparam int TIME_W = 32;
	localparam int FIN_W = 33;
	localparam int COST_W = 52;
	localparam int SUM_W = 64;

	// command codes
	localparam logic CMD_ADD = 1'b0;
	localparam logic CMD_TASK = 1'b1;

	// result status codes
	localparam logic [1:0] ST_ADDED = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd1;
	localparam logic [1:0] ST_ASSIGNED = 2'd2;
	localparam logic [1:0] ST_DROPPED = 2'd3;

	// broadcast from the sequencer to every cell
	typedef struct packed {
		logic rel_en;
		logic [TIME_W-1:0] start_time;
		logic [SAL_W-1:0] salary;
		logic [FIN_W-1:0] finish;
	} bcast_t;

	// running minimum handed along the row
	typedef struct packed {
		logic found;
		logic [SAL_W-1:0] salary;
	} cand_t;

endpackage

/* hdl/cfwd_in_if.sv */
interface cfwd_in_if;
	logic valid;
	logic ready;
	logic command;
	logic [cfwd_pkg::SAL_W-1:0] salary_rate;
	logic [cfwd_pkg::TIME_W-1:0] start_time;
	logic [cfwd_pkg::TIME_W-1:0] duration;

	modport source (output valid, command, salary_rate, start_time, duration, input ready);
	modport sink (input valid, command, salary_rate, start_time, duration, output ready);
endinterface

/* hdl/cfwd_out_if.sv */
interface cfwd_out_if;
	logic valid;
	logic ready;
	logic [1:0] status;
	logic [cfwd_pkg::SAL_W-1:0] chosen_salary;
	logic [cfwd_pkg::COST_W-1:0] task_cost;
	logic [cfwd_pkg::SUM_W-1:0] total_cost;

	modport source (output valid, status, chosen_salary, task_cost, total_cost, input ready);
	modport sink (input valid, status, chosen_salary, task_cost, total_cost, output ready);
endinterface

/* hdl/cfwd_cell.sv */
module cfwd_cell #(
	parameter int IW = 6,
	parameter int IDX = 0
) (
	input logic clk,
	input logic arst_n,
	input cfwd_pkg::bcast_t bc,
	input logic add_sel,
	input logic assign_sel,
	input cfwd_pkg::cand_t cand_in,
	input logic [IW-1:0] idx_in,
	output cfwd_pkg::cand_t cand_out,
	output logic [IW-1:0] idx_out
);

	logic valid_q;
	logic busy_q;
	logic [cfwd_pkg::FIN_W-1:0] finish_q;
	logic [cfwd_pkg::SAL_W-1:0] salary_q;
	cfwd_pkg::cand_t cand_q;
	logic [IW-1:0] idx_q;
	logic take_own;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			busy_q <= 1'b0;
		end else if (add_sel) begin
			valid_q <= 1'b1;
			busy_q <= 1'b0;
		end else if (assign_sel) begin
			busy_q <= 1'b1;
		end else if (bc.rel_en && busy_q &&
				finish_q <= {1'b0, bc.start_time}) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (add_sel) begin
			salary_q <= bc.salary;
			finish_q <= '0;
		end else if (assign_sel) begin
			finish_q <= bc.finish;
		end
	end

	// lower index keeps the place on equal salary
	assign take_own = valid_q && !busy_q &&
		(!cand_in.found || salary_q < cand_in.salary);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cand_q <= '0;
			idx_q <= '0;
		end else if (take_own) begin
			cand_q.found <= 1'b1;
			cand_q.salary <= salary_q;
			idx_q <= IW'(IDX);
		end else begin
			cand_q <= cand_in;
			idx_q <= idx_in;
		end
	end

	assign cand_out = cand_q;
	assign idx_out = idx_q;

endmodule

/* hdl/cheapest_free_worker_dispatch.sv */
// cheapest_free_worker_dispatch: a table of WORKERS workers held in a row of
// cells, one worker per cell. An add-worker request writes the next free
// cell, or reports the table full. For a task request the release of
// finished workers is broadcast to all cells at once, then the cheapest free
// worker is found by a running minimum that moves one cell along the row
// each clock, so the row length WORKERS sets the task latency. A 20x32
// multiply and the 64-bit running total follow in states of their own; a
// dropped task skips the charge to the total. One request is worked on at a
// time; a new request is taken while the previous result still waits in the
// output register. Equal salaries go to the lowest table place. The total
// wraps modulo 2^64; a task with no free worker is dropped and costs nothing.
module cheapest_free_worker_dispatch #(
	parameter int WORKERS = cfwd_pkg::WORKERS_DEF
) (
	input logic clk,
	input logic arst_n,
	cfwd_in_if.sink request,
	cfwd_out_if.source result
);

	localparam int IW = (WORKERS > 1) ? $clog2(WORKERS) : 1;
	localparam int CW = $clog2(WORKERS + 1);

	// sequencer states
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_WAVE = 3'd1;
	localparam logic [2:0] S_MUL = 3'd2;
	localparam logic [2:0] S_CHARGE = 3'd3;
	localparam logic [2:0] S_DONE = 3'd4;

	logic [2:0] state_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] wave_q;
	logic [cfwd_pkg::TIME_W-1:0] start_q;
	logic [cfwd_pkg::TIME_W-1:0] dur_q;
	logic [cfwd_pkg::SAL_W-1:0] win_sal_q;
	logic [IW-1:0] win_idx_q;
	logic [cfwd_pkg::COST_W-1:0] cost_q;
	logic [cfwd_pkg::SUM_W-1:0] sum_q;

	// pending result, then the output register
	logic [1:0] pend_st_q;
	logic [cfwd_pkg::SAL_W-1:0] pend_sal_q;
	logic [cfwd_pkg::COST_W-1:0] pend_cost_q;
	logic out_valid_q;
	logic [1:0] out_st_q;
	logic [cfwd_pkg::SAL_W-1:0] out_sal_q;
	logic [cfwd_pkg::COST_W-1:0] out_cost_q;
	logic [cfwd_pkg::SUM_W-1:0] out_sum_q;

	logic req_fire;
	logic do_add;
	logic do_assign;
	logic out_free;
	cfwd_pkg::bcast_t bc;
	cfwd_pkg::cand_t chain [WORKERS+1];
	logic [IW-1:0] chain_idx [WORKERS+1];

	assign request.ready = (state_q == S_IDLE);
	assign req_fire = request.valid && request.ready;
	assign do_add = req_fire && request.command == cfwd_pkg::CMD_ADD &&
		count_q != CW'(WORKERS);
	assign do_assign = (state_q == S_CHARGE);
	assign out_free = !out_valid_q || result.ready;

	// release is broadcast on the edge that takes a task
	always_comb begin
		bc.rel_en = req_fire && request.command == cfwd_pkg::CMD_TASK;
		bc.start_time = request.start_time;
		bc.salary = request.salary_rate;
		bc.finish = {1'b0, start_q} + {1'b0, dur_q};
	end

	assign chain[0] = '0;
	assign chain_idx[0] = '0;

	// the row of worker cells
	for (genvar i = 0; i < WORKERS; i++) begin : g_cell
		cfwd_cell #(
			.IW(IW),
			.IDX(i)
		) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.bc(bc),
			.add_sel(do_add && count_q[IW-1:0] == IW'(i)),
			.assign_sel(do_assign && win_idx_q == IW'(i)),
			.cand_in(chain[i]),
			.idx_in(chain_idx[i]),
			.cand_out(chain[i+1]),
			.idx_out(chain_idx[i+1])
		);
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			wave_q <= '0;
			sum_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (req_fire) begin
						if (request.command == cfwd_pkg::CMD_TASK) begin
							wave_q <= '0;
							state_q <= S_WAVE;
						end else begin
							if (do_add) begin
								count_q <= count_q + CW'(1);
							end
							state_q <= S_DONE;
						end
					end
				end
				S_WAVE: begin
					// the wave runs until the minimum reaches the row's end
					wave_q <= wave_q + CW'(1);
					if (wave_q == CW'(WORKERS - 1)) begin
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					state_q <= chain[WORKERS].found ? S_CHARGE : S_DONE;
				end
				S_CHARGE: begin
					sum_q <= sum_q + cfwd_pkg::SUM_W'(cost_q);
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			start_q <= request.start_time;
			dur_q <= request.duration;
			pend_sal_q <= '0;
			pend_cost_q <= '0;
			if (request.command == cfwd_pkg::CMD_ADD) begin
				pend_st_q <= do_add ? cfwd_pkg::ST_ADDED : cfwd_pkg::ST_FULL;
			end else begin
				pend_st_q <= cfwd_pkg::ST_DROPPED;
			end
		end
		if (state_q == S_MUL) begin
			win_sal_q <= chain[WORKERS].salary;
			win_idx_q <= chain_idx[WORKERS];
			cost_q <= cfwd_pkg::COST_W'(chain[WORKERS].salary) *
				cfwd_pkg::COST_W'(dur_q);
		end
		if (state_q == S_CHARGE) begin
			pend_st_q <= cfwd_pkg::ST_ASSIGNED;
			pend_sal_q <= win_sal_q;
			pend_cost_q <= cost_q;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			out_st_q <= pend_st_q;
			out_sal_q <= pend_sal_q;
			out_cost_q <= pend_cost_q;
			out_sum_q <= sum_q;
		end
	end

	assign result.valid = out_valid_q;
	assign result.status = out_st_q;
	assign result.chosen_salary = out_sal_q;
	assign result.task_cost = out_cost_q;
	assign result.total_cost = out_sum_q;

endmodule

/* tb/sv/cheapest_free_worker_dispatch_test.sv */
module cheapest_free_worker_dispatch_test;
	import cfwd_pkg::*;

	localparam int WORKERS = WORKERS_DEF;
	localparam int RANDOM_REQUESTS = 1700;
	// cycles before the run is declared hung
	localparam int CYCLE_LIMIT = 1_000_000;
	// the receiver's long hold-off starts once this many requests have gone in
	localparam int LONG_HOLD_AT = 300;
	localparam int LONG_HOLD_CYCLES = 400;
	// where in the random part the sender waits for the block to drain
	localparam int DRAIN_AT = 850;

	typedef struct {
		logic command;
		logic [SAL_W-1:0] salary_rate;
		logic [TIME_W-1:0] start_time;
		logic [TIME_W-1:0] duration;
		bit wait_idle;
	} request_t;

	typedef struct {
		logic [1:0] status;
		logic [SAL_W-1:0] chosen_salary;
		logic [COST_W-1:0] task_cost;
		logic [SUM_W-1:0] total_cost;
	} outcome_t;

	// receiver behaviour, redrawn at random while the run goes on
	typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_PULSE} rx_mode_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	cfwd_in_if request_ch ();
	cfwd_out_if result_ch ();

	cheapest_free_worker_dispatch dut (
		.clk(clk),
		.arst_n(arst_n),
		.request(request_ch),
		.result(result_ch)
	);

	always #4 clk = ~clk;

	// requests still to be offered, and outcomes still to arrive
	request_t request_backlog[$];
	outcome_t due_outcomes[$];

	int fault_count = 0;
	int result_count = 0;
	int accepted_requests = 0;
	int cycle_count = 0;

	// own copy of the worker table
	logic [SAL_W-1:0] rate_of [WORKERS];
	logic [FIN_W-1:0] finish_at [WORKERS];
	bit on_job [WORKERS];
	int crew_size = 0;
	logic [SUM_W-1:0] cost_sum = '0;

	// works out the result of one request and moves the table on
	function automatic outcome_t dispatch_predict(logic cmd, logic [SAL_W-1:0] sal,
			logic [TIME_W-1:0] start, logic [TIME_W-1:0] dur);
		outcome_t o;
		int pick;
		logic [COST_W-1:0] cost;
		o.status = ST_ADDED;
		o.chosen_salary = '0;
		o.task_cost = '0;
		pick = -1;
		if (cmd == CMD_ADD) begin
			if (crew_size >= WORKERS) begin
				o.status = ST_FULL;
			end else begin
				rate_of[crew_size] = sal;
				finish_at[crew_size] = '0;
				on_job[crew_size] = 1'b0;
				crew_size++;
			end
		end else begin
			// free the finished workers, then keep the cheapest free one, lowest place first
			for (int i = 0; i < crew_size; i++) begin
				if (on_job[i] && finish_at[i] <= {1'b0, start})
					on_job[i] = 1'b0;
				if (!on_job[i] && (pick < 0 || rate_of[i] < rate_of[pick]))
					pick = i;
			end
			if (pick < 0) begin
				o.status = ST_DROPPED;
			end else begin
				// both operands widen to the 52-bit product
				cost = sal * 0 + rate_of[pick] * dur;
				on_job[pick] = 1'b1;
				finish_at[pick] = {1'b0, start} + {1'b0, dur};
				cost_sum = cost_sum + cost;
				o.status = ST_ASSIGNED;
				o.chosen_salary = rate_of[pick];
				o.task_cost = cost;
			end
		end
		o.total_cost = cost_sum;
		return o;
	endfunction

	task automatic report_mismatch(string msg);
		fault_count++;
		$display("mismatch: %s", msg);
	endtask

	task automatic queue_request(logic cmd, logic [SAL_W-1:0] sal, logic [TIME_W-1:0] start,
			logic [TIME_W-1:0] dur, bit hold);
		request_t r;
		r.command = cmd;
		r.salary_rate = sal;
		r.start_time = start;
		r.duration = dur;
		r.wait_idle = hold;
		request_backlog.insert(request_backlog.size(), r);
	endtask

	// salaries lean towards a few small values so that ties are common
	function automatic logic [SAL_W-1:0] pick_salary();
		logic [SAL_W-1:0] s;
		case ($urandom_range(0, 9))
			0, 1, 2: s = SAL_W'($urandom_range(0, 3));
			3: s = '1;
			4: s = SAL_W'($urandom_range(0, 40));
			default: s = SAL_W'($urandom);
		endcase
		return s;
	endfunction

	// driver: bursts of requests with random gaps between them
	int burst_left = 1;
	int gap_left = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if (request_ch.valid && request_ch.ready) begin
				due_outcomes.insert(due_outcomes.size(), dispatch_predict(request_ch.command,
					request_ch.salary_rate, request_ch.start_time, request_ch.duration));
				accepted_requests <= accepted_requests + 1;
			end
			// the slot is free when nothing is offered or the offer was just taken
			if (!request_ch.valid || request_ch.ready) begin
				if (gap_left > 0) begin
					gap_left--;
					request_ch.valid <= 1'b0;
				end else if (request_backlog.size() != 0 &&
						!(request_backlog[0].wait_idle && due_outcomes.size() != 0)) begin
					request_t r;
					r = request_backlog.pop_front();
					request_ch.command <= r.command;
					request_ch.salary_rate <= r.salary_rate;
					request_ch.start_time <= r.start_time;
					request_ch.duration <= r.duration;
					request_ch.valid <= 1'b1;
					burst_left--;
					if (burst_left <= 0) begin
						burst_left = $urandom_range(1, 24);
						case ($urandom_range(0, 9))
							0, 1, 2, 3: gap_left = 0;
							4, 5, 6, 7: gap_left = $urandom_range(1, 8);
							8: gap_left = $urandom_range(9, 40);
							default: gap_left = $urandom_range(41, 100);
						endcase
					end
				end else begin
					request_ch.valid <= 1'b0;
				end
			end
		end
	end

	// receiver: its own stall pattern, plus one long hold-off to back the block up
	rx_mode_t rx_mode = RX_OPEN;
	int rx_mode_left = 0;
	int hold_left = 0;
	bit long_hold_done = 1'b0;

	always @(posedge clk) begin
		if (arst_n) begin
			if (hold_left > 0) begin
				hold_left--;
				result_ch.ready <= 1'b0;
			end else if (!long_hold_done && accepted_requests >= LONG_HOLD_AT) begin
				long_hold_done = 1'b1;
				hold_left = LONG_HOLD_CYCLES;
				result_ch.ready <= 1'b0;
			end else begin
				if (rx_mode_left == 0) begin
					rx_mode = rx_mode_t'($urandom_range(0, 3));
					rx_mode_left = $urandom_range(20, 200);
				end else begin
					rx_mode_left--;
				end
				case (rx_mode)
					RX_OPEN: result_ch.ready <= 1'b1;
					RX_COIN: result_ch.ready <= $urandom_range(0, 1);
					RX_SPARSE: result_ch.ready <= ($urandom_range(0, 3) == 0);
					default: result_ch.ready <= ((cycle_count % 7) < 3);
				endcase
			end
		end
	end

	// monitor: every result against the oldest outstanding outcome
	always @(posedge clk) begin
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (due_outcomes.size() == 0) begin
				report_mismatch($sformatf("result with nothing outstanding, status %0d",
					result_ch.status));
			end else begin
				outcome_t want;
				want = due_outcomes.pop_front();
				if (result_ch.status !== want.status)
					report_mismatch($sformatf("result %0d status got %0d want %0d",
						result_count, result_ch.status, want.status));
				if (result_ch.chosen_salary !== want.chosen_salary)
					report_mismatch($sformatf("result %0d chosen_salary got 0x%0h want 0x%0h",
						result_count, result_ch.chosen_salary, want.chosen_salary));
				if (result_ch.task_cost !== want.task_cost)
					report_mismatch($sformatf("result %0d task_cost got 0x%0h want 0x%0h",
						result_count, result_ch.task_cost, want.task_cost));
				if (result_ch.total_cost !== want.total_cost)
					report_mismatch($sformatf("result %0d total_cost got 0x%0h want 0x%0h",
						result_count, result_ch.total_cost, want.total_cost));
			end
			result_count++;
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("cheapest_free_worker_dispatch test failed");
			$finish;
		end
	end

	initial begin
		logic [TIME_W-1:0] now;
		logic [TIME_W-1:0] st;
		logic [TIME_W-1:0] du;
		bit hold;

		request_ch.valid = 1'b0;
		request_ch.command = CMD_ADD;
		request_ch.salary_rate = '0;
		request_ch.start_time = '0;
		request_ch.duration = '0;
		result_ch.ready = 1'b0;

		// directed opening: empty table, salary extremes, ties, release at the exact finish,
		// all busy, the largest start and duration, and unused fields at their extremes
		queue_request(CMD_TASK, '1, 32'd0, 32'd5, 1'b0);          // empty table, dropped
		queue_request(CMD_ADD, '1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
		queue_request(CMD_ADD, '0, 32'd0, 32'd0, 1'b0);
		queue_request(CMD_ADD, '0, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 1'b0); // equal salary
		queue_request(CMD_ADD, 20'h5A5A5, 32'h5A5A_5A5A, 32'hA5A5_A5A5, 1'b0);
		queue_request(CMD_TASK, '0, 32'd0, 32'hFFFF_FFFF, 1'b0);  // tie, lowest place wins
		queue_request(CMD_TASK, '1, 32'd0, 32'd10, 1'b0);
		queue_request(CMD_TASK, '0, 32'd5, 32'd3, 1'b0);
		queue_request(CMD_TASK, '0, 32'd5, 32'hFFFF_FFFF, 1'b0);  // dearest worker, top cost
		queue_request(CMD_TASK, '0, 32'd7, 32'd1, 1'b0);          // everyone busy
		queue_request(CMD_TASK, '1, 32'd8, 32'd0, 1'b0);          // freed exactly at finish
		queue_request(CMD_TASK, '0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0); // finish needs 33 bits
		queue_request(CMD_ADD, 20'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
		queue_request(CMD_TASK, '1, 32'hFFFF_FFFF, 32'd7, 1'b0);
		queue_request(CMD_TASK, 20'hAAAAA, 32'hFFFF_FFFF, 32'h8000_0000, 1'b0);
		queue_request(CMD_ADD, 20'h80000, 32'd0, 32'd0, 1'b0);
		queue_request(CMD_TASK, '0, 32'hFFFF_FFFF, 32'hFFFF_0000, 1'b0);
		queue_request(CMD_TASK, '0, 32'hFFFF_FFFF, 32'd3, 1'b0);

		// random part: a time base that mostly creeps forward so workers keep coming free;
		// adds are rare enough that the table only fills about two fifths of the way through
		now = '0;
		for (int n = 0; n < RANDOM_REQUESTS; n++) begin
			hold = (n == 0 || n == DRAIN_AT);
			if ($urandom_range(0, 99) < 9) begin
				queue_request(CMD_ADD, pick_salary(), $urandom, $urandom, hold);
			end else begin
				if ($urandom_range(0, 199) == 0)
					now = $urandom_range(0, 32'hE000_0000);
				else
					now = now + $urandom_range(0, 6);
				case ($urandom_range(0, 99))
					0: begin
						st = $urandom;
						du = $urandom_range(0, 20);
					end
					1: begin
						// long job, likely never freed again
						st = now;
						du = $urandom;
					end
					2, 3: begin
						st = now;
						du = '0;
					end
					default: begin
						st = now - $urandom_range(0, 3);
						du = $urandom_range(1, 60);
					end
				endcase
				queue_request(CMD_TASK, SAL_W'($urandom), st, du, hold);
			end
		end

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// wait for the stimulus to go in and every outcome to come back
		while (request_backlog.size() != 0 || request_ch.valid || due_outcomes.size() != 0)
			@(posedge clk);
		// a little longer, to catch stray results
		repeat (WORKERS + 16) @(posedge clk);

		if (fault_count == 0) begin
			$display("cheapest_free_worker_dispatch test passed");
		end else begin
			$display("cheapest_free_worker_dispatch test failed");
		end
		$finish;
	end

endmodule
